[hdl/ptw_pkg.sv]
// Shared types and constants for the two-level page-table walker.
// No dependencies; every other file in hdl/ except ptw_ram.sv imports this package.
`timescale 1ns / 1ps

package ptw_pkg;

  localparam int PTW_MEM_WORDS = 4096;

  localparam int ENTRY_W = 32;
  localparam int VA_W    = 32;
  localparam int FRAME_W = 20;

  // Entry bit positions
  localparam int BIT_PRESENT = 0;
  localparam int BIT_RW      = 1;
  localparam int BIT_PS      = 7;

  // Item kinds
  localparam logic KIND_STORE = 1'b0;
  localparam logic KIND_XLATE = 1'b1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIR,
    ST_TBL
  } ptw_state_t;

  // Controller to datapath
  typedef struct packed {
    logic clear_en;
    logic accept;
    logic tbl_rd;
    logic res_dir;
    logic res_tbl;
  } ptw_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clear_last;
    logic in_valid;
    logic in_kind;
    logic dir_leaf;
    logic out_free;
  } ptw_sts_t;

endpackage

[hdl/ptw_if.sv]
// Valid/ready channel interfaces for walker items and results.
// Depends on ptw_pkg for field widths.
`timescale 1ns / 1ps

interface ptw_in_if import ptw_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               kind;
  logic [VA_W-1:0]    address;
  logic [ENTRY_W-1:0] entry_data;
  logic [FRAME_W-1:0] directory_base;

  modport source (output valid, kind, address, entry_data, directory_base, input ready);
  modport sink   (input valid, kind, address, entry_data, directory_base, output ready);
endinterface

interface ptw_out_if import ptw_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            translated;
  logic [VA_W-1:0] phys_address;
  logic            large_page;
  logic            writable;

  modport source (output valid, translated, phys_address, large_page, writable, input ready);
  modport sink   (input valid, translated, phys_address, large_page, writable, output ready);
endinterface

[hdl/ptw_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps

module ptw_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[hdl/ptw_ctrl.sv]
// Walk controller: clearing pass, item acceptance and walk sequencing.
// Depends on ptw_pkg for the state enum and command/status structs.
`timescale 1ns / 1ps

module ptw_ctrl import ptw_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  ptw_sts_t sts,
  output ptw_cmd_t cmd,
  output logic     in_ready
);

  ptw_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (sts.clear_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (sts.in_valid && sts.in_kind == KIND_XLATE) state_nxt = ST_DIR;
      end
      ST_DIR: begin
        // table read needs no output space; a result waits for it
        priority if (!sts.dir_leaf) state_nxt = ST_TBL;
        else if (sts.out_free)      state_nxt = ST_IDLE;
      end
      ST_TBL: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clear_en = 1'b1;
      end
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = sts.in_valid;
      end
      ST_DIR: begin
        cmd.tbl_rd  = !sts.dir_leaf;
        cmd.res_dir = sts.dir_leaf && sts.out_free;
      end
      ST_TBL: begin
        cmd.res_tbl = sts.out_free;
      end
    endcase
  end

  a_tbl_follows_rd: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.tbl_rd |=> state_r == ST_TBL)
    else $error("table read not followed by table check");

  a_tbl_after_dir: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_TBL |-> $past(state_r) == ST_DIR || $past(state_r) == ST_TBL)
    else $error("table check entered without directory check");

  a_clear_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear_en |-> !cmd.accept && !cmd.tbl_rd && !in_ready)
    else $error("item activity during clearing pass");

endmodule

[hdl/ptw_dp.sv]
// Walk datapath: table memory, clear counter, item registers, result register.
// Depends on ptw_pkg and ptw_ram.
`timescale 1ns / 1ps

module ptw_dp import ptw_pkg::*; #(
  parameter int MEM_WORDS = PTW_MEM_WORDS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ptw_cmd_t           cmd,
  output ptw_sts_t           sts,
  input  logic               in_valid,
  input  logic               in_kind,
  input  logic [VA_W-1:0]    in_address,
  input  logic [ENTRY_W-1:0] in_entry_data,
  input  logic [FRAME_W-1:0] in_directory_base,
  input  logic               wp,
  input  logic               out_ready,
  output logic               out_valid,
  output logic               out_translated,
  output logic [VA_W-1:0]    out_phys_address,
  output logic               out_large_page,
  output logic               out_writable
);

  localparam int              AW        = $clog2(MEM_WORDS);
  localparam logic [31:0]     MEM_LIMIT = 32'(MEM_WORDS);
  localparam logic [AW-1:0]   CLR_LAST  = AW'(MEM_WORDS - 1);

  logic [AW-1:0]      clr_cnt_r;
  logic [VA_W-1:0]    va_r;
  logic               dir_oob_r;
  logic               tbl_oob_r;
  logic               out_valid_r, out_valid_nxt;
  logic               translated_r;
  logic [VA_W-1:0]    phys_r;
  logic               large_r;
  logic               writable_r;

  logic [29:0]        dir_idx;
  logic [29:0]        tbl_idx;
  logic               dir_oob;
  logic               tbl_oob;
  logic               st_oob;
  logic               mem_we;
  logic [AW-1:0]      mem_wr_addr;
  logic [ENTRY_W-1:0] mem_wr_data;
  logic               mem_rd_en;
  logic [AW-1:0]      mem_rd_addr;
  logic [ENTRY_W-1:0] rd_data;
  logic               dir_ok;
  logic               tbl_ok;
  logic               res_ok;
  logic [VA_W-1:0]    res_phys;
  logic               load;

  // Word indexes of the two levels
  assign dir_idx = {in_directory_base, in_address[31:22]};
  assign tbl_idx = {rd_data[31:12], va_r[21:12]};
  assign dir_oob = {2'b00, dir_idx} >= MEM_LIMIT;
  assign tbl_oob = {2'b00, tbl_idx} >= MEM_LIMIT;
  assign st_oob  = in_address >= MEM_LIMIT;

  assign mem_we      = cmd.clear_en || (cmd.accept && in_kind == KIND_STORE && !st_oob);
  assign mem_wr_addr = cmd.clear_en ? clr_cnt_r : in_address[AW-1:0];
  assign mem_wr_data = cmd.clear_en ? '0 : in_entry_data;
  assign mem_rd_en   = (cmd.accept && in_kind == KIND_XLATE) || cmd.tbl_rd;
  assign mem_rd_addr = cmd.tbl_rd ? tbl_idx[AW-1:0] : dir_idx[AW-1:0];

  ptw_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MEM_WORDS)
  ) u_mem (
    .clk     (clk),
    .we      (mem_we),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clear_en) begin
      clr_cnt_r <= clr_cnt_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      va_r      <= in_address;
      dir_oob_r <= dir_oob;
    end
    if (cmd.tbl_rd) begin
      tbl_oob_r <= tbl_oob;
    end
  end

  // Read data holds while a result waits, as no new read is issued
  assign dir_ok   = !dir_oob_r && rd_data[BIT_PRESENT];
  assign tbl_ok   = !tbl_oob_r && rd_data[BIT_PRESENT];
  assign res_ok   = cmd.res_dir ? dir_ok : tbl_ok;
  assign res_phys = cmd.res_dir ? {rd_data[31:22], va_r[21:0]}
                                : {rd_data[31:12], va_r[11:0]};
  assign load     = cmd.res_dir || cmd.res_tbl;

  always_comb begin
    out_valid_nxt = out_valid_r;
    priority if (load)      out_valid_nxt = 1'b1;
    else if (out_ready)     out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      translated_r <= res_ok;
      phys_r       <= res_ok ? res_phys : '0;
      large_r      <= res_ok && cmd.res_dir;
      writable_r   <= res_ok && (!wp || rd_data[BIT_RW]);
    end
  end

  assign sts.clear_last = clr_cnt_r == CLR_LAST;
  assign sts.in_valid   = in_valid;
  assign sts.in_kind    = in_kind;
  assign sts.dir_leaf   = !dir_ok || rd_data[BIT_PS];
  assign sts.out_free   = !out_valid_r || out_ready;

  assign out_valid        = out_valid_r;
  assign out_translated   = translated_r;
  assign out_phys_address = phys_r;
  assign out_large_page   = large_r;
  assign out_writable     = writable_r;

  a_load_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> !out_valid_r || out_ready)
    else $error("result overwritten before it was taken");

  a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !translated_r |-> phys_r == '0 && !large_r && !writable_r)
    else $error("fault result carries nonzero fields");

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.res_dir && cmd.res_tbl))
    else $error("two results formed in one cycle");

endmodule

[hdl/two_level_page_table_walk.sv]
// Two-level page-table walker, top level: channels, APB register, controller, datapath.
// Depends on ptw_pkg, ptw_if, ptw_ctrl and ptw_dp.
//
//   port        dir   handshake        carries
//   in_ch       in    valid/ready      kind, address, entry_data, directory_base
//   out_ch      out   valid/ready      translated, phys_address, large_page, writable
//   APB         in    psel/penable     write_protect at every paddr
//
// A store item is a single memory write. A translate item reads the directory
// entry and, unless that ends the walk, the table entry: each level is one
// registered read of the single table memory port.
// After reset a clearing pass zeroes every memory word with in_ch.ready
// low; register writes are taken meanwhile.
// A finished result waits in the output register; the walk holds until
// it is free, and no item is taken while the walk holds.
`timescale 1ns / 1ps

module two_level_page_table_walk import ptw_pkg::*; #(
  parameter int MEM_WORDS = PTW_MEM_WORDS
) (
  input  logic        clk,
  input  logic        rst_n,
  ptw_in_if.sink      in_ch,
  ptw_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  ptw_cmd_t cmd;
  ptw_sts_t sts;
  logic     wp_r;
  logic     in_ready;
  logic     cfg_wr;

  // Only one register, so every word address of the port selects it
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && paddr[1:0] == paddr[1:0];
  assign prdata = {31'b0, wp_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b1;
    end else if (cfg_wr) begin
      wp_r <= pwdata[0];
    end
  end

  ptw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .sts      (sts),
    .cmd      (cmd),
    .in_ready (in_ready)
  );

  ptw_dp #(
    .MEM_WORDS (MEM_WORDS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_valid          (in_ch.valid),
    .in_kind           (in_ch.kind),
    .in_address        (in_ch.address),
    .in_entry_data     (in_ch.entry_data),
    .in_directory_base (in_ch.directory_base),
    .wp                (wp_r),
    .out_ready         (out_ch.ready),
    .out_valid         (out_ch.valid),
    .out_translated    (out_ch.translated),
    .out_phys_address  (out_ch.phys_address),
    .out_large_page    (out_ch.large_page),
    .out_writable      (out_ch.writable)
  );

  assign in_ch.ready = in_ready;

endmodule

[tb/testbench.sv]
// Self-checking testbench for the two-level page-table walker.
// Drives store and translate items, writes write_protect over APB and checks every
// walk result against a shadow table memory. Needs ptw_pkg, ptw_if and the walker RTL.
`timescale 1ns / 1ps

module testbench;
  import ptw_pkg::*;

  localparam logic [1:0] REG_WRITE_PROTECT = 2'd0;
  localparam int SETTLE_CYCLES  = 8;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int SHADOW_AW = $clog2(PTW_MEM_WORDS);
  localparam logic [31:0] SHADOW_LIMIT = 32'(PTW_MEM_WORDS);

  typedef struct packed {
    logic            translated;
    logic [VA_W-1:0] phys_address;
    logic            large_page;
    logic            writable;
  } walk_result_t;

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [1:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  ptw_in_if  in_ch ();
  ptw_out_if out_ch ();

  two_level_page_table_walk u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Shadow copy of the walker state
  logic [ENTRY_W-1:0] shadow_tables [PTW_MEM_WORDS];
  logic               shadow_wp;
  walk_result_t       expected_walks [$];

  int error_count  = 0;
  int src_idle_pct = 0;
  int snk_idle_pct = 0;
  int hold_left    = 0;

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  function automatic walk_result_t walk_tables(input logic [VA_W-1:0] va,
                                               input logic [FRAME_W-1:0] dbase);
    walk_result_t       res;
    logic [29:0]        dir_idx;
    logic [29:0]        tbl_idx;
    logic [ENTRY_W-1:0] pde;
    logic [ENTRY_W-1:0] pte;
    res = '0;
    dir_idx = {dbase, va[31:22]};
    if ({2'b00, dir_idx} >= SHADOW_LIMIT) return res;
    pde = shadow_tables[dir_idx[SHADOW_AW-1:0]];
    if (!pde[BIT_PRESENT]) return res;
    if (pde[BIT_PS]) begin
      res.translated   = 1'b1;
      res.phys_address = {pde[31:22], va[21:0]};
      res.large_page   = 1'b1;
      res.writable     = !shadow_wp || pde[BIT_RW];
      return res;
    end
    tbl_idx = {pde[31:12], va[21:12]};
    if ({2'b00, tbl_idx} >= SHADOW_LIMIT) return res;
    pte = shadow_tables[tbl_idx[SHADOW_AW-1:0]];
    if (!pte[BIT_PRESENT]) return res;
    res.translated   = 1'b1;
    res.phys_address = {pte[31:12], va[11:0]};
    res.writable     = !shadow_wp || pte[BIT_RW];
    return res;
  endfunction

  function automatic void record_item(input logic k, input logic [VA_W-1:0] a,
                                      input logic [ENTRY_W-1:0] d,
                                      input logic [FRAME_W-1:0] b);
    if (k == KIND_STORE) begin
      // drop stores beyond the table memory
      if (a < SHADOW_LIMIT) shadow_tables[a[SHADOW_AW-1:0]] = d;
    end else begin
      expected_walks.push_back(walk_tables(a, b));
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // Called just after a rising edge; returns at the edge that accepts the item
  task automatic send_item(input logic k, input logic [VA_W-1:0] a,
                           input logic [ENTRY_W-1:0] d, input logic [FRAME_W-1:0] b);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.kind           <= k;
    in_ch.address        <= a;
    in_ch.entry_data     <= d;
    in_ch.directory_base <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    record_item(k, a, d, b);
  endtask

  task automatic write_reg(input logic [1:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == REG_WRITE_PROTECT) shadow_wp = data[0];
  endtask

  // Stop offering items, wait for every result, then let the walker settle
  task automatic wait_walks_done();
    int i;
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_walks.size() != 0) @(posedge clk);
    for (i = 0; i < SETTLE_CYCLES; i++) @(posedge clk);
  endtask

  task automatic test_reset_faults();
    src_idle_pct = 0;
    snk_idle_pct = 0;
    write_reg(REG_WRITE_PROTECT, 32'd1);
    send_item(KIND_XLATE, 32'h0000_0000, 32'h0, 20'h00000);
    send_item(KIND_XLATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 20'hFFFFF);
    wait_walks_done();
  endtask

  task automatic test_directed_walks();
    // self-referencing entry at word 0: directory and table are the same word
    send_item(KIND_STORE, 32'd0, 32'h0000_0001, 20'h00000);
    send_item(KIND_XLATE, 32'h0000_0000, 32'h0, 20'h00000);
    // large page, all ones
    send_item(KIND_STORE, 32'd1023, 32'hFFC0_0083, 20'h00000);
    send_item(KIND_XLATE, 32'hFFFF_FFFF, 32'h0, 20'h00000);
    // small pages through table frame 2, both ends of the table
    send_item(KIND_STORE, 32'd3072, 32'h0000_2001, 20'hFFFFF);
    send_item(KIND_STORE, 32'd2048, 32'hFFFF_F003, 20'h00000);
    send_item(KIND_XLATE, 32'h0000_0ABC, 32'hFFFF_FFFF, 20'h00003);
    send_item(KIND_STORE, 32'd3071, 32'h1234_5001, 20'h00000);
    send_item(KIND_XLATE, 32'h003F_F123, 32'h0, 20'h00003);
    // table frame beyond the memory
    send_item(KIND_STORE, 32'd3073, 32'h0000_4001, 20'h00000);
    send_item(KIND_XLATE, 32'h0040_0000, 32'h0, 20'h00003);
    // size bit without present bit
    send_item(KIND_STORE, 32'd3074, 32'h0000_0080, 20'h00000);
    send_item(KIND_XLATE, 32'h0080_0000, 32'h0, 20'h00003);
    // directory entry never written
    send_item(KIND_XLATE, 32'h00C0_0000, 32'h0, 20'h00003);
    // table entry not present
    send_item(KIND_STORE, 32'd2049, 32'h0000_0002, 20'h00000);
    send_item(KIND_XLATE, 32'h0000_1000, 32'h0, 20'h00003);
    // last word of the memory
    send_item(KIND_STORE, 32'd4095, 32'hFFFF_FFFF, 20'h00000);
    send_item(KIND_XLATE, 32'hFFC0_0001, 32'h0, 20'h00003);
    // stores beyond the memory are dropped
    send_item(KIND_STORE, 32'd4096, 32'hDEAD_BEEF, 20'h00000);
    send_item(KIND_STORE, 32'hFFFF_FFFF, 32'h0000_0000, 20'hFFFFF);
    // directory beyond the memory
    send_item(KIND_XLATE, 32'h0000_0000, 32'h0, 20'h00004);
    wait_walks_done();
    write_reg(REG_WRITE_PROTECT, 32'd0);
    send_item(KIND_XLATE, 32'h003F_F123, 32'h0, 20'h00003);
    send_item(KIND_XLATE, 32'h0040_0000, 32'h0, 20'h00003);
    wait_walks_done();
    write_reg(REG_WRITE_PROTECT, 32'd1);
  endtask

  // Mostly build a directory and table entry, then translate through them
  task automatic test_random_walks(input int n_items, input int src_pct, input int snk_pct);
    int                 sent;
    int                 pick;
    int                 n_xlate;
    int                 j;
    logic [VA_W-1:0]    va;
    logic [ENTRY_W-1:0] pde;
    logic [ENTRY_W-1:0] pte;
    logic [FRAME_W-1:0] dbase;
    logic [FRAME_W-1:0] tframe;
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    sent = 0;
    while (sent < n_items) begin
      pick  = $urandom_range(99);
      va    = $urandom();
      dbase = FRAME_W'($urandom_range(3));
      if (pick < 60) begin
        tframe = ($urandom_range(9) == 0) ? FRAME_W'($urandom()) : FRAME_W'($urandom_range(3));
        pde = {tframe, 12'($urandom())};
        pde[BIT_PRESENT] = ($urandom_range(7) != 0);
        pde[BIT_PS]      = ($urandom_range(2) == 0);
        send_item(KIND_STORE, 32'({dbase, va[31:22]}), pde, FRAME_W'($urandom()));
        sent++;
        if (!pde[BIT_PS]) begin
          pte = $urandom();
          pte[BIT_PRESENT] = ($urandom_range(7) != 0);
          send_item(KIND_STORE, 32'({pde[31:12], va[21:12]}), pte, FRAME_W'($urandom()));
          sent++;
        end
        n_xlate = $urandom_range(1, 3);
        for (j = 0; j < n_xlate; j++) begin
          send_item(KIND_XLATE, {va[31:12], 12'($urandom())}, $urandom(), dbase);
          sent++;
        end
      end else if (pick < 85) begin
        send_item(KIND_XLATE, va, $urandom(), dbase);
        sent++;
      end else if (pick < 92) begin
        if ($urandom_range(1) == 0) begin
          send_item(KIND_STORE, $urandom(), $urandom(), FRAME_W'($urandom()));
        end else begin
          send_item(KIND_STORE, 32'($urandom_range(PTW_MEM_WORDS - 1)), $urandom(),
                    FRAME_W'($urandom()));
        end
        sent++;
      end else begin
        send_item(KIND_XLATE, va, $urandom(), FRAME_W'($urandom()));
        sent++;
      end
    end
    wait_walks_done();
  endtask

  // Hold the result side off so the walker fills and stalls its input
  task automatic test_output_backpressure();
    int i;
    src_idle_pct = 0;
    snk_idle_pct = 0;
    hold_left = HOLD_OFF_CYCLES;
    for (i = 0; i < 40; i++) begin
      send_item(KIND_XLATE, $urandom(), $urandom(), FRAME_W'($urandom_range(3)));
    end
    wait_walks_done();
  endtask

  initial begin : result_sink
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    walk_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_walks.size() == 0) begin
        report_mismatch("unexpected result", out_ch.phys_address, 32'h0);
      end else begin
        want = expected_walks.pop_front();
        if (out_ch.translated !== want.translated)
          report_mismatch("translated", 32'(out_ch.translated), 32'(want.translated));
        if (out_ch.phys_address !== want.phys_address)
          report_mismatch("phys_address", out_ch.phys_address, want.phys_address);
        if (out_ch.large_page !== want.large_page)
          report_mismatch("large_page", 32'(out_ch.large_page), 32'(want.large_page));
        if (out_ch.writable !== want.writable)
          report_mismatch("writable", 32'(out_ch.writable), 32'(want.writable));
      end
    end
  end

  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("FAIL two_level_page_table_walk");
    $finish;
  end

  initial begin
    shadow_tables        = '{default: '0};
    shadow_wp            = 1'b1;
    rst_n                = 1'b0;
    psel                 = 1'b0;
    penable              = 1'b0;
    pwrite               = 1'b0;
    paddr                = REG_WRITE_PROTECT;
    pwdata               = '0;
    in_ch.valid          = 1'b0;
    in_ch.kind           = KIND_STORE;
    in_ch.address        = '0;
    in_ch.entry_data     = '0;
    in_ch.directory_base = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_faults();
    test_directed_walks();
    test_random_walks(240, 31, 46);
    write_reg(REG_WRITE_PROTECT, 32'd0);
    test_random_walks(240, 46, 31);
    write_reg(REG_WRITE_PROTECT, 32'd1);
    test_random_walks(240, 0, 0);
    test_output_backpressure();
    if (error_count == 0) begin
      $display("PASS two_level_page_table_walk");
    end else begin
      $display("FAIL two_level_page_table_walk");
    end
    $finish;
  end

endmodule
